FILE: src/slca_pkg.sv
// shared constants, types and saturating arithmetic for the step length cluster averager
package slca_pkg;

   // accumulator width and hit limit
   localparam int SUM_WIDTH     = 48;
   localparam int MAX_HITS      = 65535;
   localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLUSTER_LENGTH = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_OFFSET       = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic add;
      logic close;
      logic div_step;
      logic load_out;
   } slca_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic close;
   } slca_status_type;

   // signed accumulate, clamped to the accumulator range
   function automatic logic signed [SUM_WIDTH-1:0] sat_add_signed(
      input logic signed [SUM_WIDTH-1:0] acc,
      input logic signed [32:0]          val
   );
      logic signed [SUM_WIDTH:0]   total;
      logic signed [SUM_WIDTH-1:0] result;
      total = (SUM_WIDTH+1)'(acc) + (SUM_WIDTH+1)'(val);
      if (total[SUM_WIDTH] != total[SUM_WIDTH-1]) begin
         if (total[SUM_WIDTH]) begin
            result = {1'b1, {(SUM_WIDTH-1){1'b0}}};
         end else begin
            result = {1'b0, {(SUM_WIDTH-1){1'b1}}};
         end
      end else begin
         result = total[SUM_WIDTH-1:0];
      end
      return result;
   endfunction

   // unsigned 40 bit accumulate, clamped to all ones
   function automatic logic [39:0] sat_add_u40(
      input logic [39:0] acc,
      input logic [23:0] val
   );
      logic [40:0] total;
      logic [39:0] result;
      total = {1'b0, acc} + {17'b0, val};
      if (total[40]) begin
         result = {40{1'b1}};
      end else begin
         result = total[39:0];
      end
      return result;
   endfunction

endpackage

FILE: src/slca_div.sv
// restoring divider, one quotient bit per cycle while step is high, signed dividend, saturated 32 bit quotient
module slca_div
   import slca_pkg::*;
(
   input  logic                        clock,
   input  logic                        load,
   input  logic                        step,
   input  logic signed [SUM_WIDTH-1:0] dividend,
   input  logic [15:0]                 divisor,
   output logic signed [31:0]          quotient
);

   logic                 neg_ff;
   logic [15:0]          divisor_ff;
   logic [15:0]          rem_ff;
   logic [SUM_WIDTH-1:0] quo_ff;

   logic [SUM_WIDTH-1:0] magnitude;
   logic [16:0]          rem_shift;
   logic                 fits;
   logic [16:0]          rem_diff;
   logic                 neg_over;
   logic                 pos_over;

   // dividend magnitude at load
   assign magnitude = dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;

   // one restoring step
   assign rem_shift = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign fits      = rem_shift >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff     <= dividend[SUM_WIDTH-1];
         divisor_ff <= divisor;
         rem_ff     <= '0;
         quo_ff     <= magnitude;
      end else if (step) begin
         rem_ff <= fits ? rem_diff[15:0] : rem_shift[15:0];
         quo_ff <= {quo_ff[SUM_WIDTH-2:0], fits};
      end
   end

   // sign restore and clamp to 32 bit signed
   assign pos_over = |quo_ff[SUM_WIDTH-1:31];
   assign neg_over = (|quo_ff[SUM_WIDTH-1:32]) || (quo_ff[31] && (|quo_ff[30:0]));

   always_comb begin
      if (neg_ff) begin
         quotient = neg_over ? 32'sh8000_0000 : (~quo_ff[31:0] + 32'd1);
      end else begin
         quotient = pos_over ? 32'sh7FFF_FFFF : quo_ff[31:0];
      end
   end

endmodule

FILE: src/slca_datapath.sv
// configuration registers, hit capture, cluster accumulators, dividers and result registers
module slca_datapath
   import slca_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  slca_cmd_type               cmd,
   output slca_status_type            status,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic signed [31:0]         req_hit_time,
   input  logic signed [31:0]         req_hit_x,
   input  logic signed [31:0]         req_hit_y,
   input  logic signed [31:0]         req_hit_z,
   input  logic [23:0]                req_electrons,
   input  logic [23:0]                req_step_length,
   output logic signed [31:0]         rsp_mean_time,
   output logic signed [31:0]         rsp_mean_x,
   output logic signed [31:0]         rsp_mean_y,
   output logic signed [31:0]         rsp_mean_z,
   output logic [39:0]                rsp_electron_total,
   output logic [15:0]                rsp_hit_count,
   output logic                       rsp_forced_close
);

   // configuration
   logic [23:0]        cluster_length_ff;
   logic signed [31:0] y_offset_ff;

   // captured hit
   logic signed [31:0] hit_time_ff;
   logic signed [31:0] hit_x_ff;
   logic signed [32:0] hit_y_ff;
   logic signed [31:0] hit_z_ff;
   logic [23:0]        electrons_ff;
   logic [23:0]        step_ff;

   // open cluster sums
   logic signed [SUM_WIDTH-1:0] time_sum_ff;
   logic signed [SUM_WIDTH-1:0] x_sum_ff;
   logic signed [SUM_WIDTH-1:0] y_sum_ff;
   logic signed [SUM_WIDTH-1:0] z_sum_ff;
   logic [39:0]                 electron_sum_ff;
   logic [39:0]                 length_sum_ff;
   logic [15:0]                 hits_ff;
   logic [23:0]                 latched_length_ff;

   // closed cluster payload
   logic [39:0] electron_close_ff;
   logic [15:0] hits_close_ff;
   logic        forced_ff;

   logic [39:0]        length_in;
   logic [15:0]        hits_in;
   logic [23:0]        target;
   logic               by_length;
   logic               by_count;
   logic signed [31:0] q_time;
   logic signed [31:0] q_x;
   logic signed [31:0] q_y;
   logic signed [31:0] q_z;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_length_ff <= '0;
         y_offset_ff       <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_CLUSTER_LENGTH: cluster_length_ff <= csr_wdata[23:0];
            CSR_Y_OFFSET:       y_offset_ff       <= csr_wdata;
         endcase
      end
   end

   // hit capture, y offset applied here
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_time_ff  <= req_hit_time;
         hit_x_ff     <= req_hit_x;
         hit_y_ff     <= 33'(req_hit_y) + 33'(y_offset_ff);
         hit_z_ff     <= req_hit_z;
         electrons_ff <= req_electrons;
         step_ff      <= req_step_length;
      end
   end

   // close decision on the updated sums
   assign length_in = sat_add_u40(length_sum_ff, step_ff);
   assign hits_in   = (hits_ff != 16'hFFFF) ? (hits_ff + 16'd1) : hits_ff;

   always_comb begin
      if (cluster_length_ff != 24'd0) begin
         target = cluster_length_ff;
      end else if (latched_length_ff != 24'd0) begin
         target = latched_length_ff;
      end else begin
         target = step_ff;
      end
   end

   assign by_length    = length_in >= {16'b0, target};
   assign by_count     = hits_in >= 16'(MAX_HITS);
   assign status.close = by_length || by_count;

   // accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         time_sum_ff       <= '0;
         x_sum_ff          <= '0;
         y_sum_ff          <= '0;
         z_sum_ff          <= '0;
         electron_sum_ff   <= '0;
         length_sum_ff     <= '0;
         hits_ff           <= '0;
         latched_length_ff <= '0;
      end else if (cmd.add) begin
         time_sum_ff     <= sat_add_signed(time_sum_ff, 33'(hit_time_ff));
         x_sum_ff        <= sat_add_signed(x_sum_ff, 33'(hit_x_ff));
         y_sum_ff        <= sat_add_signed(y_sum_ff, hit_y_ff);
         z_sum_ff        <= sat_add_signed(z_sum_ff, 33'(hit_z_ff));
         electron_sum_ff <= sat_add_u40(electron_sum_ff, electrons_ff);
         length_sum_ff   <= length_in;
         hits_ff         <= hits_in;
         if (cluster_length_ff == 24'd0 && latched_length_ff == 24'd0) begin
            latched_length_ff <= step_ff;
         end
      end else if (cmd.close) begin
         time_sum_ff     <= '0;
         x_sum_ff        <= '0;
         y_sum_ff        <= '0;
         z_sum_ff        <= '0;
         electron_sum_ff <= '0;
         length_sum_ff   <= '0;
         hits_ff         <= '0;
      end
   end

   // closed cluster payload kept while dividing
   always_ff @(posedge clock) begin
      if (cmd.add) begin
         forced_ff <= by_count && !by_length;
      end
      if (cmd.close) begin
         electron_close_ff <= electron_sum_ff;
         hits_close_ff     <= hits_ff;
      end
   end

   // four dividers run side by side
   slca_div u_div_time (
      .clock    (clock),
      .load     (cmd.close),
      .step     (cmd.div_step),
      .dividend (time_sum_ff),
      .divisor  (hits_ff),
      .quotient (q_time)
   );

   slca_div u_div_x (
      .clock    (clock),
      .load     (cmd.close),
      .step     (cmd.div_step),
      .dividend (x_sum_ff),
      .divisor  (hits_ff),
      .quotient (q_x)
   );

   slca_div u_div_y (
      .clock    (clock),
      .load     (cmd.close),
      .step     (cmd.div_step),
      .dividend (y_sum_ff),
      .divisor  (hits_ff),
      .quotient (q_y)
   );

   slca_div u_div_z (
      .clock    (clock),
      .load     (cmd.close),
      .step     (cmd.div_step),
      .dividend (z_sum_ff),
      .divisor  (hits_ff),
      .quotient (q_z)
   );

   // result beat registers
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_mean_time      <= q_time;
         rsp_mean_x         <= q_x;
         rsp_mean_y         <= q_y;
         rsp_mean_z         <= q_z;
         rsp_electron_total <= electron_close_ff;
         rsp_hit_count      <= hits_close_ff;
         rsp_forced_close   <= forced_ff;
      end
   end

endmodule

FILE: src/slca_ctrl.sv
// sequencer: hit accept, accumulate, close, divide and result hand-off
module slca_ctrl
   import slca_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output slca_cmd_type    cmd,
   input  slca_status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      ADD,
      CLOSE,
      DIVIDE,
      OUTPUT
   } state_type;

   state_type                state_ff;
   logic [DIV_CNT_WIDTH-1:0] count_ff;
   logic                     rsp_valid_ff;
   logic                     out_free;

   // result register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // commands decoded from state
   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == IDLE) && req_valid;
      cmd.add      = (state_ff == ADD);
      cmd.close    = (state_ff == CLOSE);
      cmd.div_step = (state_ff == DIVIDE);
      cmd.load_out = (state_ff == OUTPUT) && out_free;
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   // state, divide counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  state_ff <= ADD;
               end
            end
            ADD: begin
               state_ff <= status.close ? CLOSE : IDLE;
            end
            CLOSE: begin
               count_ff <= '0;
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               if (count_ff == DIV_CNT_WIDTH'(SUM_WIDTH - 1)) begin
                  state_ff <= OUTPUT;
               end else begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            OUTPUT: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

FILE: src/step_length_cluster_averager_unit.sv
// top level of the step length cluster averager
//
// Hits arrive as beats on the req_ channel (valid/stall); each accepted beat is
// added to the open cluster sums. When the summed step length reaches the
// cluster length, or the hit count reaches its limit, one cluster beat leaves
// on the rsp_ channel with the mean time and position, the electron total,
// the hit count and the forced close flag. A trailing partial cluster is kept.
// A hit that does not close a cluster passes through the accumulate state before
// the next hit is taken. A closing hit shows its result beat after accumulate,
// close, the divide steps in the four radix-2 dividers (one quotient bit per
// accumulator bit), and the load of the result register; the next hit is
// taken only once the sequencer is back in idle.
// The csr_ port writes cluster_length (index 0) and y_offset (index 1); write
// only while no hit is in progress.
// Reset clears the sums, the latched cluster length, the configuration registers
// and the result valid. A stalled result beat stays in its register while the next
// hits are accepted; a further closing hit waits until the beat is taken.
module step_length_cluster_averager_unit
   import slca_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [31:0]         req_hit_time,
   input  logic signed [31:0]         req_hit_x,
   input  logic signed [31:0]         req_hit_y,
   input  logic signed [31:0]         req_hit_z,
   input  logic [23:0]                req_electrons,
   input  logic [23:0]                req_step_length,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_mean_time,
   output logic signed [31:0]         rsp_mean_x,
   output logic signed [31:0]         rsp_mean_y,
   output logic signed [31:0]         rsp_mean_z,
   output logic [39:0]                rsp_electron_total,
   output logic [15:0]                rsp_hit_count,
   output logic                       rsp_forced_close,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_wdata
);

   slca_cmd_type    cmd;
   slca_status_type status;

   // sequencer
   slca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // sums, dividers and result registers
   slca_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_hit_time       (req_hit_time),
      .req_hit_x          (req_hit_x),
      .req_hit_y          (req_hit_y),
      .req_hit_z          (req_hit_z),
      .req_electrons      (req_electrons),
      .req_step_length    (req_step_length),
      .rsp_mean_time      (rsp_mean_time),
      .rsp_mean_x         (rsp_mean_x),
      .rsp_mean_y         (rsp_mean_y),
      .rsp_mean_z         (rsp_mean_z),
      .rsp_electron_total (rsp_electron_total),
      .rsp_hit_count      (rsp_hit_count),
      .rsp_forced_close   (rsp_forced_close)
   );

endmodule
